[src/stbc_pkg.sv]
package stbc_pkg;

  // Defaults for the top-level parameters.
  localparam int SPRITES_DEF   = 256;
  localparam int SIZE_BITS_DEF = 12;

  // Fixed field widths.
  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 10;
  localparam int COORD_W    = 12;
  localparam int ANCHOR_W   = 4;
  localparam int POS_W      = 16;
  localparam int SHEET_W    = 13;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_DEFINE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HOTSPOT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_SLOT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_RECT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_HEIGHT = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [SLOT_W-1:0]       sprite_slot;
    logic [COORD_W-1:0]      src_left;
    logic [COORD_W-1:0]      src_top;
    logic [COORD_W-1:0]      src_width;
    logic [COORD_W-1:0]      src_height;
    logic [ANCHOR_W-1:0]     anchor;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } stbc_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic                    blit_valid;
    logic [COORD_W-1:0]      blit_src_x;
    logic [COORD_W-1:0]      blit_src_y;
    logic [COORD_W-1:0]      blit_width;
    logic [COORD_W-1:0]      blit_height;
    logic signed [POS_W-1:0] dest_x;
    logic signed [POS_W-1:0] dest_y;
  } stbc_result_t;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic mem_rd;
    logic calc1;
    logic calc2;
    logic calc3;
  } stbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } stbc_stat_t;

endpackage

[src/stbc_ctrl.sv]
module stbc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  stbc_pkg::stbc_stat_t stat,
  output stbc_pkg::stbc_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import stbc_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CALC1 = 6'b001000,
    S_CALC2 = 6'b010000,
    S_CALC3 = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_CALC3);
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CALC1;
      end
      S_CALC1: begin
        cmd.calc1  = 1'b1;
        state_next = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2  = 1'b1;
        state_next = S_CALC3;
      end
      S_CALC3: begin
        cmd.calc3  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[src/stbc_datapath.sv]
module stbc_datapath #(
  parameter int NUM_SPRITES = stbc_pkg::SPRITES_DEF,
  parameter int SIZE_BITS   = stbc_pkg::SIZE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  stbc_pkg::stbc_cmd_t                    cmd,
  output stbc_pkg::stbc_stat_t                   stat,
  input  logic                                   cfg_write,
  input  logic [stbc_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [stbc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  stbc_pkg::stbc_item_t                   item,
  output stbc_pkg::stbc_result_t                 result
);
  import stbc_pkg::*;

  localparam int IDX_W   = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
  localparam int ENTRY_W = 2 * COORD_W;
  localparam int WIDE_W  = POS_W + 2;

  // Hotspot modes along one axis.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_MID   = 2'd1;
  localparam logic [1:0] MODE_LAST  = 2'd2;

  // Anchor codes; every other code is the top-left corner.
  localparam logic [ANCHOR_W-1:0] ANC_TOP_MID   = 4'd1;
  localparam logic [ANCHOR_W-1:0] ANC_TOP_RIGHT = 4'd2;
  localparam logic [ANCHOR_W-1:0] ANC_MID_LEFT  = 4'd3;
  localparam logic [ANCHOR_W-1:0] ANC_MIDDLE    = 4'd4;
  localparam logic [ANCHOR_W-1:0] ANC_MID_RIGHT = 4'd5;
  localparam logic [ANCHOR_W-1:0] ANC_BOT_LEFT  = 4'd6;
  localparam logic [ANCHOR_W-1:0] ANC_BOT_MID   = 4'd7;
  localparam logic [ANCHOR_W-1:0] ANC_BOT_RIGHT = 4'd8;

  // Returns the horizontal mode in the upper two bits, vertical in the lower.
  function automatic logic [3:0] anchor_modes(input logic [ANCHOR_W-1:0] a);
    logic [3:0] m;
    unique case (a)
      ANC_TOP_MID:   m = {MODE_MID,   MODE_START};
      ANC_TOP_RIGHT: m = {MODE_LAST,  MODE_START};
      ANC_MID_LEFT:  m = {MODE_START, MODE_MID};
      ANC_MIDDLE:    m = {MODE_MID,   MODE_MID};
      ANC_MID_RIGHT: m = {MODE_LAST,  MODE_MID};
      ANC_BOT_LEFT:  m = {MODE_START, MODE_LAST};
      ANC_BOT_MID:   m = {MODE_MID,   MODE_LAST};
      ANC_BOT_RIGHT: m = {MODE_LAST,  MODE_LAST};
      default:       m = {MODE_START, MODE_START};
    endcase
    return m;
  endfunction

  function automatic logic [COORD_W-1:0] hot_offset(input logic [COORD_W-1:0] size,
                                                    input logic [1:0] mode);
    logic [COORD_W-1:0] r;
    unique case (mode)
      MODE_MID:  r = size >> 1;
      MODE_LAST: r = (size == '0) ? '0 : size - COORD_W'(1);
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sext(input logic [POS_W-1:0] v);
    return {{(WIDE_W-POS_W){v[POS_W-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] zext(input logic [COORD_W-1:0] v);
    return {{(WIDE_W-COORD_W){1'b0}}, v};
  endfunction

  // Configuration registers.
  logic [POS_W-1:0]   clip_left, clip_top, clip_right, clip_bottom;
  logic [SHEET_W-1:0] sheet_width, sheet_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left    <= POS_W'(0);
      clip_top     <= POS_W'(0);
      clip_right   <= POS_W'(319);
      clip_bottom  <= POS_W'(255);
      sheet_width  <= SHEET_W'(320);
      sheet_height <= SHEET_W'(256);
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_CLIP_LEFT:    clip_left    <= cfg_data;
        REG_CLIP_TOP:     clip_top     <= cfg_data;
        REG_CLIP_RIGHT:   clip_right   <= cfg_data;
        REG_CLIP_BOTTOM:  clip_bottom  <= cfg_data;
        REG_SHEET_WIDTH:  sheet_width  <= cfg_data[SHEET_W-1:0];
        REG_SHEET_HEIGHT: sheet_height <= cfg_data[SHEET_W-1:0];
        default: ;
      endcase
    end
  end

  // Command word latched on start.
  stbc_item_t itm;
  logic       slot_ok;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      itm     <= item;
      slot_ok <= ({1'b0, item.sprite_slot} < (SLOT_W+1)'(NUM_SPRITES));
    end
  end

  // Clearing pass address.
  logic [IDX_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  assign stat.clear_last = (clr_addr == IDX_W'(NUM_SPRITES - 1));

  // Sprite table.
  logic [ENTRY_W-1:0] origin_store [NUM_SPRITES];
  logic [ENTRY_W-1:0] extent_store [NUM_SPRITES];
  logic [ENTRY_W-1:0] anchor_store [NUM_SPRITES];
  logic [ENTRY_W-1:0] rd_org, rd_ext, rd_anc;

  logic [IDX_W-1:0]   tbl_addr;
  logic [3:0]         modes;
  logic               is_define, is_hotspot, size_ok, rect_ok, def_ok, hot_ok;
  logic               org_we, anc_we;
  logic [COORD_W-1:0] hw_size, hh_size;
  logic [ENTRY_W-1:0] org_wdata, ext_wdata, anc_wdata;

  assign tbl_addr   = cmd.clear ? clr_addr : itm.sprite_slot[IDX_W-1:0];
  assign modes      = anchor_modes(itm.anchor);
  assign is_define  = (itm.command == CMD_DEFINE);
  assign is_hotspot = (itm.command == CMD_HOTSPOT);
  assign size_ok    = ((itm.src_left >> SIZE_BITS) == '0) &&
                      ((itm.src_top >> SIZE_BITS) == '0) &&
                      ((itm.src_width >> SIZE_BITS) == '0) &&
                      ((itm.src_height >> SIZE_BITS) == '0);
  assign rect_ok    = (({1'b0, itm.src_left} + {1'b0, itm.src_width}) <= sheet_width) &&
                      (({1'b0, itm.src_top} + {1'b0, itm.src_height}) <= sheet_height);
  assign def_ok     = slot_ok && is_define && size_ok && rect_ok;
  assign hot_ok     = slot_ok && is_hotspot;
  assign hw_size    = is_define ? itm.src_width  : rd_ext[ENTRY_W-1:COORD_W];
  assign hh_size    = is_define ? itm.src_height : rd_ext[COORD_W-1:0];

  assign org_we    = cmd.clear || (cmd.calc1 && def_ok);
  assign anc_we    = cmd.clear || (cmd.calc1 && (def_ok || hot_ok));
  assign org_wdata = cmd.clear ? '0 : {itm.src_left, itm.src_top};
  assign ext_wdata = cmd.clear ? '0 : {itm.src_width, itm.src_height};
  assign anc_wdata = cmd.clear ? '0 : {hot_offset(hw_size, modes[3:2]),
                                       hot_offset(hh_size, modes[1:0])};

  always_ff @(posedge clk) begin
    if (org_we) begin
      origin_store[tbl_addr] <= org_wdata;
      extent_store[tbl_addr] <= ext_wdata;
    end
    if (anc_we) begin
      anchor_store[tbl_addr] <= anc_wdata;
    end
    if (cmd.mem_rd) begin
      rd_org <= origin_store[tbl_addr];
      rd_ext <= extent_store[tbl_addr];
      rd_anc <= anchor_store[tbl_addr];
    end
  end

  // Clip window, sign extended.
  logic signed [WIDE_W-1:0] cl, ct, cr, cb;
  assign cl = sext(clip_left);
  assign ct = sext(clip_top);
  assign cr = sext(clip_right);
  assign cb = sext(clip_bottom);

  // First stage: status and hotspot subtraction.
  logic [STATUS_W-1:0]      status1, status2;
  logic                     draw1, draw2;
  logic signed [WIDE_W-1:0] x1, y1, w1, h1;
  logic [COORD_W-1:0]       sl1, st1;
  logic [STATUS_W-1:0]      status_c1;

  always_comb begin
    status_c1 = STAT_OK;
    if (itm.command == CMD_DEFINE || itm.command == CMD_HOTSPOT ||
        itm.command == CMD_DRAW) begin
      if (!slot_ok) begin
        status_c1 = STAT_BAD_SLOT;
      end else if (is_define && !(size_ok && rect_ok)) begin
        status_c1 = STAT_BAD_RECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      status1 <= status_c1;
      draw1   <= slot_ok && (itm.command == CMD_DRAW);
      x1      <= sext(itm.pos_x) - zext(rd_anc[ENTRY_W-1:COORD_W]);
      y1      <= sext(itm.pos_y) - zext(rd_anc[COORD_W-1:0]);
      w1      <= zext(rd_ext[ENTRY_W-1:COORD_W]);
      h1      <= zext(rd_ext[COORD_W-1:0]);
      sl1     <= rd_org[ENTRY_W-1:COORD_W];
      st1     <= rd_org[COORD_W-1:0];
    end
  end

  // Second stage: reject test and trim at the left and top edges.
  logic signed [WIDE_W-1:0] x2, y2, w2, h2;
  logic [COORD_W-1:0]       sl2, st2;
  logic signed [WIDE_W-1:0] dx, dy;
  logic                     reject;

  assign dx     = cl - x1;
  assign dy     = ct - y1;
  assign reject = (x1 > cr) || ((x1 + w1) <= cl) || (y1 > cb) || ((y1 + h1) <= ct);

  always_ff @(posedge clk) begin
    if (cmd.calc2) begin
      status2 <= status1;
      draw2   <= draw1 && !reject;
      if (x1 < cl) begin
        x2  <= cl;
        w2  <= w1 - dx;
        sl2 <= sl1 + dx[COORD_W-1:0];
      end else begin
        x2  <= x1;
        w2  <= w1;
        sl2 <= sl1;
      end
      if (y1 < ct) begin
        y2  <= ct;
        h2  <= h1 - dy;
        st2 <= st1 + dy[COORD_W-1:0];
      end else begin
        y2  <= y1;
        h2  <= h1;
        st2 <= st1;
      end
    end
  end

  // Third stage: trim at the right and bottom edges, form the result.
  logic signed [WIDE_W-1:0] w3, h3;
  logic                     visible;
  stbc_result_t             result_next;

  always_comb begin
    w3 = w2;
    h3 = h2;
    if ((x2 + w2 - WIDE_W'(1)) > cr) begin
      w3 = cr - x2 + WIDE_W'(1);
    end
    if ((y2 + h2 - WIDE_W'(1)) > cb) begin
      h3 = cb - y2 + WIDE_W'(1);
    end
    visible     = draw2 && (w3 > $signed(WIDE_W'(0))) && (h3 > $signed(WIDE_W'(0)));
    result_next = '0;
    result_next.status = status2;
    if (visible) begin
      result_next.blit_valid  = 1'b1;
      result_next.blit_src_x  = sl2;
      result_next.blit_src_y  = st2;
      result_next.blit_width  = w3[COORD_W-1:0];
      result_next.blit_height = h3[COORD_W-1:0];
      result_next.dest_x      = x2[POS_W-1:0];
      result_next.dest_y      = y2[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc3) begin
      result <= result_next;
    end
  end

endmodule

[src/sprite_table_blit_clipper_top.sv]
// Sprite table with blit rectangle clipping.
// A word taken while idle goes through the controller's fixed sequence of table read,
// hotspot subtraction, left/top trim and right/bottom trim before its result strobe;
// busy stays high until the sequence ends, so the next word waits for it.
// Reset: synchronous, active high; the table is then cleared one entry a cycle
// (busy high) and results go out with no stall from the receiver.
module sprite_table_blit_clipper_top #(
  parameter int NUM_SPRITES = stbc_pkg::SPRITES_DEF,
  parameter int SIZE_BITS   = stbc_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  stbc_pkg::stbc_item_t            item,
  output logic                            done,
  output stbc_pkg::stbc_result_t          result,
  input  logic                            cfg_write,
  input  logic [stbc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [stbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stbc_pkg::*;

  // The controller steps each word through the datapath. A word is taken when
  // start is high and busy is low; the result is valid on the result port in the
  // single cycle in which done is high. Busy drops in that same cycle, so the
  // next word can be taken while the previous result is being delivered.
  stbc_cmd_t  cmd;
  stbc_stat_t stat;

  stbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the configuration registers, the sprite table and the
  // clipping stages. Writes to the table land during the hotspot stage, so a
  // following word always reads the updated entry.
  stbc_datapath #(
    .NUM_SPRITES (NUM_SPRITES),
    .SIZE_BITS   (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result)
  );

endmodule

[src/stbc_checker.sv]
module stbc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input stbc_pkg::stbc_result_t result
);
  import stbc_pkg::*;

  // A taken word always gets its result after the fixed sequence.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("result strobe missing after accepted word");

  // The block goes busy right after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A result is shown only when the block is ready for the next word.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A visible blit only comes with an ok status.
  a_valid_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.blit_valid) |-> (result.status == STAT_OK))
    else $error("blit valid with error status");

  // An empty result carries no rectangle.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.blit_valid) |->
      (result.blit_width == '0 && result.blit_height == '0 &&
       result.dest_x == '0 && result.dest_y == '0))
    else $error("rectangle fields set on empty result");

endmodule

bind sprite_table_blit_clipper_top stbc_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
